>>> rtl/core/r2fft_pkg.sv
// Shared types, constants and helper functions of the radix-2 FFT unit.
package r2fft_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TW_W     = 16;
    localparam int BIN_W    = 22;
    localparam int MAX_LG   = 6;
    localparam int MIN_LG   = 2;
    localparam int ADDR_W   = MAX_LG;
    localparam int MAX_PTS  = 1 << MAX_LG;
    localparam int WORD_W   = 2 * BIN_W;
    localparam int ROM_FRAC = 23;
    localparam int ROM_SH   = ROM_FRAC - (TW_W - 1);
    localparam int PROD_W   = BIN_W + TW_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int V_W      = SUM_W - (TW_W - 1);
    localparam int OUT_W    = 56;
    localparam int CFG_AW   = 3;
    localparam logic [CFG_AW-1:0] REG_SIZE_LOG2 = 3'd0;
    localparam logic [2:0] SIZE_RESET = 3'd6;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RDA,
        S_RDB,
        S_MUL,
        S_SUM,
        S_WRA,
        S_WRB,
        S_ERD,
        S_ECAP
    } fsm_state_t;

    typedef struct packed {
        logic cap_u;
        logic mul_en;
        logic sum_en;
    } bfly_ctl_t;

    typedef struct packed {
        logic signed [TW_W-1:0] re;
        logic signed [TW_W-1:0] im;
    } twiddle_t;

    // sin(pi*q/32) in Q1.23, q = 0..16
    localparam logic [23:0] QSINE [0:16] = '{
        24'd0, 24'd822227, 24'd1636536, 24'd2435084, 24'd3210181, 24'd3954362,
        24'd4660461, 24'd5321677, 24'd5931642, 24'd6484482, 24'd6974873,
        24'd7398092, 24'd7750063, 24'd8027397, 24'd8227423, 24'd8348215,
        24'd8388608
    };

    function automatic logic signed [TW_W-1:0] rom_value(input logic [4:0] q,
                                                         input logic neg);
        logic [4:0]  qi;
        logic [23:0] mag;
        logic [TW_W:0] m;
        qi  = (q > 5'd16) ? 5'd16 : q;
        mag = (QSINE[qi] + (24'd1 << (ROM_SH - 1))) >> ROM_SH;
        m   = mag[TW_W:0];
        if (neg)
            return TW_W'(-$signed(m));
        if (m >= (TW_W+1)'(1 << (TW_W - 1)))
            return TW_W'((1 << (TW_W - 1)) - 1);
        return TW_W'(m);
    endfunction

    // W^k on the 64-point circle, k in 0..31
    function automatic twiddle_t twiddle(input logic [4:0] k);
        twiddle_t w;
        if (k <= 5'd16)
        begin
            w.re = rom_value(5'd16 - k, 1'b0);
            w.im = rom_value(k, 1'b1);
        end
        else
        begin
            w.re = rom_value(k - 5'd16, 1'b1);
            w.im = rom_value(5'd0 - k, 1'b1);
        end
        return w;
    endfunction

    function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] i,
                                                  input logic [2:0] lg);
        logic [ADDR_W-1:0] r;
        for (int b = 0; b < ADDR_W; b++)
            r[b] = i[ADDR_W-1-b];
        return r >> (3'(MAX_LG) - lg);
    endfunction

    function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [V_W:0] x);
        if (x > (V_W+1)'((1 << (BIN_W - 1)) - 1))
            return BIN_W'((1 << (BIN_W - 1)) - 1);
        if (x < -(V_W+1)'(1 << (BIN_W - 1)))
            return BIN_W'(-(1 << (BIN_W - 1)));
        return x[BIN_W-1:0];
    endfunction

endpackage

>>> rtl/core/r2fft_ram.sv
// Generic simple dual-port RAM with registered read.
module r2fft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/r2fft_bfly.sv
// Butterfly datapath: complex multiply by the twiddle, round, add and subtract.
module r2fft_bfly import r2fft_pkg::*; (
    input  logic              clk,
    input  bfly_ctl_t         ctl,
    input  logic [WORD_W-1:0] rdata,
    input  twiddle_t          w,
    output logic [WORD_W-1:0] new_a,
    output logic [WORD_W-1:0] new_b
);

    logic signed [BIN_W-1:0]  ur_reg, ui_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [V_W-1:0]    vr_reg, vi_reg;
    logic signed [BIN_W-1:0]  br, bi;
    logic signed [SUM_W-1:0]  sr, si;

    // word layout: imag in the upper half, real in the lower
    assign br = rdata[BIN_W-1:0];
    assign bi = rdata[WORD_W-1:BIN_W];

    always_comb
    begin
        sr = SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg) + SUM_W'(1 << (TW_W - 2));
        si = SUM_W'(p_ri_reg) + SUM_W'(p_ir_reg) + SUM_W'(1 << (TW_W - 2));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_u)
        begin
            ur_reg <= br;
            ui_reg <= bi;
        end
        if (ctl.mul_en)
        begin
            p_rr_reg <= br * w.re;
            p_ii_reg <= bi * w.im;
            p_ri_reg <= br * w.im;
            p_ir_reg <= bi * w.re;
        end
        if (ctl.sum_en)
        begin
            vr_reg <= V_W'(sr >>> (TW_W - 1));
            vi_reg <= V_W'(si >>> (TW_W - 1));
        end
    end

    assign new_a = {sat_bin((V_W+1)'(ui_reg) + (V_W+1)'(vi_reg)),
                    sat_bin((V_W+1)'(ur_reg) + (V_W+1)'(vr_reg))};
    assign new_b = {sat_bin((V_W+1)'(ui_reg) - (V_W+1)'(vi_reg)),
                    sat_bin((V_W+1)'(ur_reg) - (V_W+1)'(vr_reg))};

endmodule

>>> rtl/core/radix2_fft_unit.sv
// Top level of the radix-2 decimation-in-time FFT unit.
// Collects 2^size_log2 complex samples (size_log2 clamped to 2..6), one per input
// request, into a 64 x 44-bit RAM at bit-reversed addresses. After the last sample it
// runs size_log2 stages of in-place butterflies, one at a time, each in the steps
// (read a, read b, multiply, round, write a, write b) through the single RAM port
// pair, then emits all bins in natural order with tlast on the final bin, one bin
// at a time, each bin held back until the output register is free. Input is taken
// only while loading; the last bin may still wait in the output register while the
// next frame loads. Writing size_log2 restarts frame loading.
module radix2_fft_unit import r2fft_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // sample_real[15:0], sample_imag[31:16]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // bin_real[21:0], bin_imag[43:22], bin_index[49:44]
    output logic              m_tlast,   // last_bin
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    fsm_state_t state_reg, state_next;
    logic [2:0]        size_reg;
    logic [ADDR_W-1:0] load_cnt_reg;
    logic [2:0]        stage_reg;
    logic [ADDR_W-2:0] k_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic              out_valid_reg;
    logic [BIN_W-1:0]  out_re_reg, out_im_reg;
    logic [ADDR_W-1:0] out_idx_reg;
    logic              out_last_reg;

    logic [2:0]        lg;
    logic [ADDR_W-1:0] n_m1;
    logic [ADDR_W-2:0] half_m1;
    logic [ADDR_W-2:0] jmask;
    logic [ADDR_W-1:0] a_idx, b_idx;
    logic [4:0]        tw_k;
    twiddle_t          w;
    bfly_ctl_t         ctl;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [WORD_W-1:0] wdata, rdata, new_a, new_b;
    logic              s_acc, m_acc, cfg_wr, frame_done, bfly_last, slot_free;
    logic signed [BIN_W-1:0] in_re, in_im;

    // effective frame size
    always_comb
    begin
        if (size_reg < 3'(MIN_LG))
            lg = 3'(MIN_LG);
        else if (size_reg > 3'(MAX_LG))
            lg = 3'(MAX_LG);
        else
            lg = size_reg;
    end
    assign n_m1    = ADDR_W'((7'd1 << lg) - 7'd1);
    assign half_m1 = n_m1[ADDR_W-1:1];

    // butterfly k of stage s: a = k with a zero bit inserted at position s
    assign jmask = (ADDR_W-1)'((6'd1 << stage_reg) - 6'd1);
    assign a_idx = {k_reg & ~jmask, 1'b0} | {1'b0, k_reg & jmask};
    assign b_idx = a_idx | (ADDR_W'(1) << stage_reg);
    assign tw_k  = 5'((k_reg & jmask) << (3'd5 - stage_reg));
    assign w     = twiddle(tw_k);

    assign s_acc      = s_tvalid && s_tready;
    assign m_acc      = m_tvalid && m_tready;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign frame_done = s_acc && (load_cnt_reg == n_m1);
    assign bfly_last  = (stage_reg == lg - 3'd1) && (k_reg == half_m1);
    assign slot_free  = !out_valid_reg || m_tready;

    assign in_re = BIN_W'($signed(s_tdata[SAMPLE_W-1:0]));
    assign in_im = BIN_W'($signed(s_tdata[2*SAMPLE_W-1:SAMPLE_W]));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: if (frame_done) state_next = S_RDA;
            S_RDA:  state_next = S_RDB;
            S_RDB:  state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_WRA;
            S_WRA:  state_next = S_WRB;
            S_WRB:  state_next = bfly_last ? S_ERD : S_RDA;
            S_ERD:  state_next = S_ECAP;
            S_ECAP:
                if (slot_free)
                    state_next = (idx_reg == n_m1) ? S_LOAD : S_ERD;
            default: state_next = S_LOAD;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = 1'b0;
        ctl      = '0;
        we       = 1'b0;
        waddr    = a_idx;
        wdata    = new_a;
        raddr    = a_idx;
        unique case (state_reg)
            S_LOAD:
            begin
                s_tready = 1'b1;
                we       = s_acc;
                waddr    = bit_rev(load_cnt_reg, lg);
                wdata    = {in_im, in_re};
            end
            S_RDA: raddr = a_idx;
            S_RDB:
            begin
                raddr     = b_idx;
                ctl.cap_u = 1'b1;
            end
            S_MUL: ctl.mul_en = 1'b1;
            S_SUM: ctl.sum_en = 1'b1;
            S_WRA: we = 1'b1;
            S_WRB:
            begin
                we    = 1'b1;
                waddr = b_idx;
                wdata = new_b;
            end
            S_ERD:  raddr = idx_reg;
            S_ECAP: raddr = idx_reg;
            default: ;
        endcase
    end

    r2fft_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_PTS)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    r2fft_bfly u_bfly (
        .clk  (clk),
        .ctl  (ctl),
        .rdata(rdata),
        .w    (w),
        .new_a(new_a),
        .new_b(new_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            size_reg      <= SIZE_RESET;
            load_cnt_reg  <= '0;
            stage_reg     <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && paddr == REG_SIZE_LOG2)
            begin
                size_reg     <= pwdata[2:0];
                load_cnt_reg <= '0;
            end
            else if (frame_done)
                load_cnt_reg <= '0;
            else if (s_acc)
                load_cnt_reg <= load_cnt_reg + 1'b1;

            if (state_reg == S_WRB)
            begin
                if (k_reg == half_m1)
                begin
                    k_reg     <= '0;
                    stage_reg <= bfly_last ? 3'd0 : stage_reg + 3'd1;
                end
                else
                    k_reg <= k_reg + 1'b1;
            end

            if (state_reg == S_ECAP && slot_free)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= (idx_reg == n_m1) ? '0 : idx_reg + 1'b1;
            end
            else if (m_acc)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ECAP && slot_free)
        begin
            out_re_reg   <= rdata[BIN_W-1:0];
            out_im_reg   <= rdata[WORD_W-1:BIN_W];
            out_idx_reg  <= idx_reg;
            out_last_reg <= (idx_reg == n_m1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W-2*BIN_W-ADDR_W)'(0), out_idx_reg, out_im_reg, out_re_reg};
    assign m_tlast  = out_last_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_SIZE_LOG2) ? {29'd0, size_reg} : 32'd0;

`ifndef SYNTHESIS
    a_frame_starts_fft: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> state_reg == S_RDA)
        else $error("full frame did not start the transform");

    a_last_bin_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> out_idx_reg == n_m1)
        else $error("last bin flagged at wrong index");

    a_no_input_in_fft: assert property (@(posedge clk) disable iff (!rst_n)
        we && state_reg != S_LOAD |-> state_reg == S_WRA || state_reg == S_WRB)
        else $error("store written outside a butterfly write");
`endif

endmodule
